### sv/stt_pkg.sv
// shared types, constants and helpers for the source text tokenizer
`timescale 1ns / 1ps

package stt_pkg;

   localparam int OFFSET_BITS_DEFAULT = 16;
   localparam int LINE_BITS_DEFAULT   = 16;

   localparam int KIND_BITS  = 9;
   localparam int FIELD_BITS = 16;

   localparam logic [KIND_BITS-1:0] KIND_END    = 9'd0;
   localparam logic [KIND_BITS-1:0] KIND_INT    = 9'd256;
   localparam logic [KIND_BITS-1:0] KIND_IDENT  = 9'd257;
   localparam logic [KIND_BITS-1:0] KIND_RETURN = 9'd258;

   localparam logic [7:0] CHAR_ZERO       = 8'h00;
   localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE      = 8'h20;
   localparam logic [7:0] CHAR_TAB        = 8'h09;
   localparam logic [7:0] CHAR_CR         = 8'h0D;
   localparam logic [7:0] CHAR_SLASH      = 8'h2F;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_DIGIT_LO   = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_HI   = 8'h39;
   localparam logic [7:0] CHAR_LOWER_LO   = 8'h61;
   localparam logic [7:0] CHAR_LOWER_HI   = 8'h7A;
   localparam logic [7:0] CHAR_UPPER_LO   = 8'h41;
   localparam logic [7:0] CHAR_UPPER_HI   = 8'h5A;

   localparam logic [2:0] KW_LENGTH = 3'd6;

   localparam int FIFO_DEPTH = 4;
   localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
   localparam int CNT_BITS   = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic [KIND_BITS-1:0]  token_kind;
      logic [FIELD_BITS-1:0] start_offset;
      logic [FIELD_BITS-1:0] token_length;
      logic [FIELD_BITS-1:0] line_number;
      logic                  last_of_run;
   } token_type;

   // up to two tokens produced by one source byte
   typedef struct packed {
      logic [1:0] count;
      token_type  tok0;
      token_type  tok1;
   } push_type;

   function automatic logic [FIELD_BITS-1:0] sat16(input logic [31:0] v);
      if (v > 32'h0000_FFFF) begin
         return 16'hFFFF;
      end
      return v[FIELD_BITS-1:0];
   endfunction

   // spelling of the return keyword
   function automatic logic [7:0] kw_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = 8'h72;
         3'd1:    c = 8'h65;
         3'd2:    c = 8'h74;
         3'd3:    c = 8'h75;
         3'd4:    c = 8'h72;
         3'd5:    c = 8'h6E;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

### sv/stt_channels.sv
// valid/ready channel interfaces for source bytes and tokens
`timescale 1ns / 1ps

interface stt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] source_byte;

   modport source (output valid, output source_byte, input ready);
   modport sink   (input valid, input source_byte, output ready);
endinterface

interface stt_rsp_if;
   logic        valid;
   logic        ready;
   logic [8:0]  token_kind;
   logic [15:0] start_offset;
   logic [15:0] token_length;
   logic [15:0] line_number;
   logic        last_of_run;

   modport source (output valid, output token_kind, output start_offset,
                   output token_length, output line_number, output last_of_run,
                   input ready);
   modport sink   (input valid, input token_kind, input start_offset,
                   input token_length, input line_number, input last_of_run,
                   output ready);
endinterface

### sv/source_text_tokenizer.sv
// top level of the source text tokenizer
// a token is queued as the byte that completes it is accepted, then shown on rsp_ch in order
// throughput: one source byte per cycle while the token queue has room; a byte
//    that yields two tokens pushes both into a four-entry token queue
// the input stalls only when the token queue has fewer than two free entries
// reset: synchronous, active high; offset 0, line 1, no open run, queue empty
`timescale 1ns / 1ps

module source_text_tokenizer #(
   parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEFAULT,
   parameter int LINE_BITS   = stt_pkg::LINE_BITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   stt_req_if.sink   req_ch,
   stt_rsp_if.source rsp_ch
);

   stt_pkg::push_type push;
   logic              push_ready;
   logic              accept;

   assign req_ch.ready = push_ready;
   assign accept       = req_ch.valid && push_ready;

   stt_scanner #(
      .OFFSET_BITS (OFFSET_BITS),
      .LINE_BITS   (LINE_BITS)
   ) u_scanner (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .source_byte (req_ch.source_byte),
      .push        (push)
   );

   stt_token_fifo u_token_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .rsp_ch     (rsp_ch)
   );

endmodule

### sv/stt_scanner.sv
// per-byte scanner state and token generation
`timescale 1ns / 1ps

module stt_scanner #(
   parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEFAULT,
   parameter int LINE_BITS   = stt_pkg::LINE_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        source_byte,
   output stt_pkg::push_type push
);

   localparam logic [2:0] MODE_IDLE    = 3'd0;
   localparam logic [2:0] MODE_INT     = 3'd1;
   localparam logic [2:0] MODE_IDENT   = 3'd2;
   localparam logic [2:0] MODE_SLASH   = 3'd3;
   localparam logic [2:0] MODE_COMMENT = 3'd4;

   localparam logic [OFFSET_BITS-1:0] OFF_MAX  = {OFFSET_BITS{1'b1}};
   localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
   localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);

   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [2:0]             mode_ff, mode_in;
   logic [OFFSET_BITS-1:0] run_start_ff, run_start_in;
   logic [LINE_BITS-1:0]   run_line_ff, run_line_in;
   logic [2:0]             kw_prog_ff, kw_prog_in;
   logic                   kw_alive_ff, kw_alive_in;

   logic                   is_digit, is_alpha, is_word, is_space;
   logic                   close_en, idle_en, ended;
   logic                   close_valid, idle_valid;
   logic [OFFSET_BITS-1:0] run_len;
   stt_pkg::token_type     close_tok, idle_tok;

   assign is_digit = (source_byte >= stt_pkg::CHAR_DIGIT_LO)
                     && (source_byte <= stt_pkg::CHAR_DIGIT_HI);
   assign is_alpha = ((source_byte >= stt_pkg::CHAR_LOWER_LO)
                      && (source_byte <= stt_pkg::CHAR_LOWER_HI))
                     || ((source_byte >= stt_pkg::CHAR_UPPER_LO)
                      && (source_byte <= stt_pkg::CHAR_UPPER_HI));
   assign is_word  = is_alpha || is_digit || (source_byte == stt_pkg::CHAR_UNDERSCORE);
   assign is_space = (source_byte == stt_pkg::CHAR_SPACE)
                     || ((source_byte >= stt_pkg::CHAR_TAB)
                      && (source_byte <= stt_pkg::CHAR_CR));

   assign run_len = pos_ff - run_start_ff;

   // token of the run that this byte closes
   always_comb begin
      close_tok              = '0;
      close_tok.start_offset = stt_pkg::sat16(32'(run_start_ff));
      close_tok.line_number  = stt_pkg::sat16(32'(run_line_ff));
      close_tok.token_length = stt_pkg::sat16(32'(run_len));
      case (mode_ff)
         MODE_INT: begin
            close_tok.token_kind = stt_pkg::KIND_INT;
         end
         MODE_IDENT: begin
            close_tok.token_kind = (kw_alive_ff && (kw_prog_ff == stt_pkg::KW_LENGTH))
                                   ? stt_pkg::KIND_RETURN : stt_pkg::KIND_IDENT;
         end
         default: begin
            close_tok.token_kind   = {1'b0, stt_pkg::CHAR_SLASH};
            close_tok.token_length = 16'd1;
         end
      endcase
   end

   always_comb begin
      pos_in       = pos_ff;
      line_in      = line_ff;
      mode_in      = mode_ff;
      run_start_in = run_start_ff;
      run_line_in  = run_line_ff;
      kw_prog_in   = kw_prog_ff;
      kw_alive_in  = kw_alive_ff;
      close_en     = 1'b0;
      idle_en      = 1'b0;
      idle_valid   = 1'b0;
      ended        = 1'b0;

      idle_tok              = '0;
      idle_tok.start_offset = stt_pkg::sat16(32'(pos_ff));
      idle_tok.line_number  = stt_pkg::sat16(32'(line_ff));
      idle_tok.token_kind   = {1'b0, source_byte};
      idle_tok.token_length = 16'd1;
      idle_tok.last_of_run  = 1'b1;

      unique case (mode_ff)
         MODE_INT: begin
            if (!is_digit) begin
               close_en = 1'b1;
               idle_en  = 1'b1;
            end
         end
         MODE_IDENT: begin
            if (is_word) begin
               if (kw_alive_ff) begin
                  if ((kw_prog_ff < stt_pkg::KW_LENGTH)
                      && (source_byte == stt_pkg::kw_char(kw_prog_ff))) begin
                     kw_prog_in = kw_prog_ff + 3'd1;
                  end else begin
                     kw_alive_in = 1'b0;
                  end
               end
            end else begin
               close_en = 1'b1;
               idle_en  = 1'b1;
            end
         end
         MODE_SLASH: begin
            if (source_byte == stt_pkg::CHAR_SLASH) begin
               mode_in = MODE_COMMENT;
            end else begin
               close_en = 1'b1;
               idle_en  = 1'b1;
            end
         end
         MODE_COMMENT: begin
            if ((source_byte == stt_pkg::CHAR_NEWLINE)
                || (source_byte == stt_pkg::CHAR_ZERO)) begin
               idle_en = 1'b1;
            end
         end
         default: begin
            idle_en = 1'b1;
         end
      endcase

      // byte seen with no run open
      if (idle_en) begin
         mode_in = MODE_IDLE;
         if (source_byte == stt_pkg::CHAR_ZERO) begin
            idle_valid            = 1'b1;
            idle_tok.token_kind   = stt_pkg::KIND_END;
            idle_tok.token_length = 16'd0;
            ended                 = 1'b1;
         end else if (is_space) begin
            if ((source_byte == stt_pkg::CHAR_NEWLINE) && (line_ff != LINE_MAX)) begin
               line_in = line_ff + LINE_ONE;
            end
         end else if (source_byte == stt_pkg::CHAR_SLASH) begin
            mode_in      = MODE_SLASH;
            run_start_in = pos_ff;
            run_line_in  = line_ff;
         end else if (is_digit) begin
            mode_in      = MODE_INT;
            run_start_in = pos_ff;
            run_line_in  = line_ff;
         end else if (is_word) begin
            mode_in      = MODE_IDENT;
            run_start_in = pos_ff;
            run_line_in  = line_ff;
            kw_alive_in  = (source_byte == stt_pkg::kw_char(3'd0));
            kw_prog_in   = (source_byte == stt_pkg::kw_char(3'd0)) ? 3'd1 : 3'd0;
         end else begin
            idle_valid = 1'b1;
         end
      end

      if (ended) begin
         pos_in       = '0;
         line_in      = LINE_ONE;
         mode_in      = MODE_IDLE;
         run_start_in = '0;
         run_line_in  = LINE_ONE;
         kw_prog_in   = 3'd0;
         kw_alive_in  = 1'b1;
      end else if (pos_ff != OFF_MAX) begin
         pos_in = pos_ff + OFFSET_BITS'(1);
      end
   end

   assign close_valid = close_en
                        && ((mode_ff == MODE_INT) || (mode_ff == MODE_IDENT)
                         || (mode_ff == MODE_SLASH));

   // pack the tokens of this byte, first one in tok0
   always_comb begin
      push       = '0;
      push.tok1  = idle_tok;
      if (close_valid) begin
         push.tok0             = close_tok;
         push.tok0.last_of_run = !idle_valid;
      end else begin
         push.tok0 = idle_tok;
      end
      if (accept) begin
         push.count = {1'b0, close_valid} + {1'b0, idle_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         line_ff      <= LINE_ONE;
         mode_ff      <= MODE_IDLE;
         run_start_ff <= '0;
         run_line_ff  <= LINE_ONE;
         kw_prog_ff   <= 3'd0;
         kw_alive_ff  <= 1'b1;
      end else if (accept) begin
         pos_ff       <= pos_in;
         line_ff      <= line_in;
         mode_ff      <= mode_in;
         run_start_ff <= run_start_in;
         run_line_ff  <= run_line_in;
         kw_prog_ff   <= kw_prog_in;
         kw_alive_ff  <= kw_alive_in;
      end
   end

`ifndef SYNTHESIS
   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      line_ff != '0)
      else $error("line count reached zero");

   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && (source_byte == stt_pkg::CHAR_ZERO) |=> (pos_ff == '0) && (line_ff == LINE_ONE))
      else $error("end byte did not restart the source");

   a_run_order: assert property (@(posedge clock) disable iff (reset)
      run_start_ff <= pos_ff)
      else $error("run start beyond current offset");

   a_pair_last: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> !push.tok0.last_of_run && push.tok1.last_of_run)
      else $error("bad last flag on token pair");
`endif

endmodule

### sv/stt_token_fifo.sv
// small token queue: up to two in per cycle while push_ready is high, one out per ready cycle
`timescale 1ns / 1ps

module stt_token_fifo (
   input  logic              clock,
   input  logic              reset,
   input  stt_pkg::push_type push,
   output logic              push_ready,
   stt_rsp_if.source         rsp_ch
);

   stt_pkg::token_type              mem_ff [stt_pkg::FIFO_DEPTH];
   logic [stt_pkg::PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [stt_pkg::PTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [stt_pkg::CNT_BITS-1:0]    count_ff, count_in;
   logic [stt_pkg::PTR_BITS-1:0]    wr_ptr_next;
   logic                            pop;
   stt_pkg::token_type              head;

   assign pop         = rsp_ch.valid && rsp_ch.ready;
   assign wr_ptr_next = wr_ptr_ff + stt_pkg::PTR_BITS'(1);
   assign wr_ptr_in   = wr_ptr_ff + stt_pkg::PTR_BITS'(push.count);
   assign rd_ptr_in   = rd_ptr_ff + stt_pkg::PTR_BITS'(pop);
   assign count_in    = count_ff + stt_pkg::CNT_BITS'(push.count)
                        - stt_pkg::CNT_BITS'(pop);
   assign push_ready  = count_ff <= stt_pkg::CNT_BITS'(stt_pkg::FIFO_DEPTH - 2);

   assign head                = mem_ff[rd_ptr_ff];
   assign rsp_ch.valid        = count_ff != '0;
   assign rsp_ch.token_kind   = head.token_kind;
   assign rsp_ch.start_offset = head.start_offset;
   assign rsp_ch.token_length = head.token_length;
   assign rsp_ch.line_number  = head.line_number;
   assign rsp_ch.last_of_run  = head.last_of_run;

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.tok0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_next] <= push.tok1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= stt_pkg::CNT_BITS'(stt_pkg::FIFO_DEPTH))
      else $error("token queue overflow");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> push_ready)
      else $error("tokens pushed without room");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      stt_pkg::PTR_BITS'(count_ff) == stt_pkg::PTR_BITS'(wr_ptr_ff - rd_ptr_ff))
      else $error("queue pointers disagree with fill count");
`endif

endmodule

### tb/source_text_tokenizer_test.sv
// self-checking testbench for the source text tokenizer: byte stream in, token stream checked
`timescale 1ns / 1ps

module source_text_tokenizer_test;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int RANDOM_BYTES   = 730;
   localparam int LONG_RUN_COUNT = 120;
   localparam int REPORT_LIMIT   = 100;

   localparam logic [7:0]  CHAR_VTAB     = 8'h0B;
   localparam logic [7:0]  CHAR_FORMFEED = 8'h0C;
   localparam logic [7:0]  CHAR_LOW_CTRL = 8'h01;
   localparam logic [7:0]  CHAR_HIGH_LO  = 8'h80;
   localparam logic [7:0]  CHAR_MAX      = 8'hFF;
   localparam logic [15:0] FIELD_MAX     = 16'hFFFF;

   localparam string KEYWORD     = "return";
   localparam string PUNCTUATION = "+-*(){};,.=<>!&|^~%#@$?:[]";

   typedef enum logic [2:0] {
      SCAN_IDLE,
      SCAN_INT,
      SCAN_IDENT,
      SCAN_SLASH,
      SCAN_COMMENT
   } scan_mode_type;

   logic clock;
   logic reset;

   stt_req_if req_ch ();
   stt_rsp_if rsp_ch ();

   source_text_tokenizer dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   logic [15:0]   next_offset;
   logic [15:0]   cur_line;
   logic [15:0]   run_offset;
   logic [15:0]   run_line;
   scan_mode_type scan_mode;
   logic [2:0]    kw_matched;
   logic          kw_ok;

   stt_pkg::token_type byte_tokens [2];
   int                 byte_token_count;
   stt_pkg::token_type expected_tokens [$];
   stt_pkg::token_type want;

   int error_count   = 0;
   int idle_cycles   = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int stall_left    = 0;
   int bytes_sent    = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic bit is_digit(input logic [7:0] b);
      return b >= stt_pkg::CHAR_DIGIT_LO && b <= stt_pkg::CHAR_DIGIT_HI;
   endfunction

   function automatic bit is_letter(input logic [7:0] b);
      return (b >= stt_pkg::CHAR_LOWER_LO && b <= stt_pkg::CHAR_LOWER_HI) ||
             (b >= stt_pkg::CHAR_UPPER_LO && b <= stt_pkg::CHAR_UPPER_HI);
   endfunction

   function automatic bit is_word(input logic [7:0] b);
      return is_letter(b) || is_digit(b) || b == stt_pkg::CHAR_UNDERSCORE;
   endfunction

   function automatic bit is_blank(input logic [7:0] b);
      return b == stt_pkg::CHAR_SPACE || (b >= stt_pkg::CHAR_TAB && b <= stt_pkg::CHAR_CR);
   endfunction

   function automatic void clear_scanner();
      next_offset = '0;
      cur_line    = 16'd1;
      scan_mode   = SCAN_IDLE;
      run_offset  = '0;
      run_line    = 16'd1;
      kw_matched  = '0;
      kw_ok       = 1'b1;
   endfunction

   function automatic void add_token(input logic [8:0] kind, input logic [15:0] start,
                                     input logic [15:0] len, input logic [15:0] line);
      if (byte_token_count < 2) begin
         byte_tokens[byte_token_count] = '{kind, start, len, line, 1'b0};
         byte_token_count++;
      end
   endfunction

   function automatic void open_run(input scan_mode_type mode);
      scan_mode  = mode;
      run_offset = next_offset;
      run_line   = cur_line;
   endfunction

   function automatic void close_run();
      case (scan_mode)
         SCAN_INT: begin
            add_token(stt_pkg::KIND_INT, run_offset, next_offset - run_offset, run_line);
         end
         SCAN_IDENT: begin
            add_token((kw_ok && kw_matched == stt_pkg::KW_LENGTH)
                      ? stt_pkg::KIND_RETURN : stt_pkg::KIND_IDENT,
                      run_offset, next_offset - run_offset, run_line);
         end
         SCAN_SLASH: begin
            add_token({1'b0, stt_pkg::CHAR_SLASH}, run_offset, 16'd1, run_line);
         end
         default: ;
      endcase
      scan_mode = SCAN_IDLE;
   endfunction

   // byte seen with no run open; returns 1 when the source ends
   function automatic bit scan_idle(input logic [7:0] b);
      if (b == stt_pkg::CHAR_ZERO) begin
         add_token(stt_pkg::KIND_END, next_offset, 16'd0, cur_line);
         return 1'b1;
      end
      if (is_blank(b)) begin
         if (b == stt_pkg::CHAR_NEWLINE && cur_line != FIELD_MAX) begin
            cur_line = cur_line + 16'd1;
         end
      end else if (b == stt_pkg::CHAR_SLASH) begin
         open_run(SCAN_SLASH);
      end else if (is_digit(b)) begin
         open_run(SCAN_INT);
      end else if (is_letter(b) || b == stt_pkg::CHAR_UNDERSCORE) begin
         open_run(SCAN_IDENT);
         kw_ok      = (b == KEYWORD[0]);
         kw_matched = kw_ok ? 3'd1 : 3'd0;
      end else begin
         add_token({1'b0, b}, next_offset, 16'd1, cur_line);
      end
      return 1'b0;
   endfunction

   function automatic void predict_byte(input logic [7:0] b);
      bit ended;
      ended = 1'b0;
      byte_token_count = 0;
      case (scan_mode)
         SCAN_INT: begin
            if (!is_digit(b)) begin
               close_run();
               ended = scan_idle(b);
            end
         end
         SCAN_IDENT: begin
            if (is_word(b)) begin
               if (kw_ok) begin
                  if (kw_matched < stt_pkg::KW_LENGTH && b == KEYWORD[kw_matched]) begin
                     kw_matched = kw_matched + 3'd1;
                  end else begin
                     kw_ok = 1'b0;
                  end
               end
            end else begin
               close_run();
               ended = scan_idle(b);
            end
         end
         SCAN_SLASH: begin
            if (b == stt_pkg::CHAR_SLASH) begin
               scan_mode = SCAN_COMMENT;
            end else begin
               close_run();
               ended = scan_idle(b);
            end
         end
         SCAN_COMMENT: begin
            if (b == stt_pkg::CHAR_NEWLINE || b == stt_pkg::CHAR_ZERO) begin
               scan_mode = SCAN_IDLE;
               ended = scan_idle(b);
            end
         end
         default: begin
            scan_mode = SCAN_IDLE;
            ended = scan_idle(b);
         end
      endcase
      if (byte_token_count > 0) begin
         byte_tokens[byte_token_count - 1].last_of_run = 1'b1;
      end
      for (int i = 0; i < byte_token_count; i++) begin
         expected_tokens.push_back(byte_tokens[i]);
      end
      if (ended) begin
         clear_scanner();
      end else if (next_offset != FIELD_MAX) begin
         next_offset = next_offset + 16'd1;
      end
   endfunction

   function automatic int gap_len();
      if ($urandom_range(0, 9) == 0) begin
         return $urandom_range(10, 40);
      end
      return $urandom_range(1, 3);
   endfunction

   function automatic int pick_pct();
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return 15;
         default: return 50;
      endcase
   endfunction

   function automatic logic [7:0] blank_byte(input int idx);
      case (idx)
         0:       return stt_pkg::CHAR_SPACE;
         1:       return stt_pkg::CHAR_TAB;
         2:       return stt_pkg::CHAR_NEWLINE;
         3:       return CHAR_VTAB;
         4:       return CHAR_FORMFEED;
         default: return stt_pkg::CHAR_CR;
      endcase
   endfunction

   function automatic logic [7:0] word_char(input bit lead);
      int n;
      n = $urandom_range(0, lead ? 52 : 62);
      if (n < 26) begin
         return 8'(stt_pkg::CHAR_LOWER_LO + n);
      end else if (n < 52) begin
         return 8'(stt_pkg::CHAR_UPPER_LO + n - 26);
      end else if (n == 52) begin
         return stt_pkg::CHAR_UNDERSCORE;
      end
      return 8'(stt_pkg::CHAR_DIGIT_LO + n - 53);
   endfunction

   function automatic string pick_word();
      case ($urandom_range(0, 7))
         0:       return "return";
         1:       return "retur";
         2:       return "returns";
         3:       return "xreturn";
         4:       return "Return";
         5:       return "r";
         6:       return "re_turn";
         default: return "ret1";
      endcase
   endfunction

   task automatic report_error(input string msg);
      if (error_count < REPORT_LIMIT) begin
         $display("ERROR at %0t: %s", $realtime, msg);
      end
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] want_v,
                              input logic [31:0] got_v);
      if (want_v !== got_v) begin
         report_error($sformatf("%s: expected %0d, got %0d", name, want_v, got_v));
      end
   endtask

   // token checker, byte monitor and watchdog
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_tokens.size() == 0) begin
               report_error($sformatf("token kind %0d with nothing expected",
                                      rsp_ch.token_kind));
            end else begin
               want = expected_tokens.pop_front();
               check_field("token_kind", 32'(want.token_kind), 32'(rsp_ch.token_kind));
               check_field("start_offset", 32'(want.start_offset),
                           32'(rsp_ch.start_offset));
               check_field("token_length", 32'(want.token_length),
                           32'(rsp_ch.token_length));
               check_field("line_number", 32'(want.line_number), 32'(rsp_ch.line_number));
               check_field("last_of_run", 32'(want.last_of_run), 32'(rsp_ch.last_of_run));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            predict_byte(req_ch.source_byte);
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("source_text_tokenizer test failed");
            $finish;
         end
      end
   end

   // token sink backpressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
         stall_left = gap_len() - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = 0;
      if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         gap = gap_len();
      end
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.source_byte <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_byte(s[i]);
      end
   endtask

   task automatic send_repeat(input logic [7:0] b, input int count);
      repeat (count) send_byte(b);
   endtask

   task automatic test_single_chars();
      send_byte(CHAR_LOW_CTRL);
      send_byte(CHAR_HIGH_LO);
      send_byte(CHAR_MAX);
      send_text("+");
      send_byte(stt_pkg::CHAR_ZERO);
   endtask

   task automatic test_runs();
      send_text("12ab 7+x_9;");
      send_byte(stt_pkg::CHAR_ZERO);
   endtask

   task automatic test_keyword();
      send_text("return returnx retur");
      send_byte(stt_pkg::CHAR_ZERO);
      send_text("return");
      send_byte(stt_pkg::CHAR_ZERO);
   endtask

   task automatic test_slash_and_comment();
      send_text("a/b//c\n/");
      send_byte(stt_pkg::CHAR_ZERO);
      send_text("//x");
      send_byte(stt_pkg::CHAR_ZERO);
   endtask

   task automatic test_whitespace();
      for (int i = 0; i < 6; i++) begin
         send_byte(blank_byte(i));
      end
      send_text("x\n\ny");
      send_byte(stt_pkg::CHAR_ZERO);
   endtask

   task automatic test_long_runs();
      send_idle_pct = 0;
      stall_pct     = 0;
      send_repeat(stt_pkg::CHAR_NEWLINE, LONG_RUN_COUNT);
      send_text("ab+");
      send_byte(stt_pkg::CHAR_ZERO);
      send_text("1");
      send_repeat(stt_pkg::CHAR_DIGIT_HI, LONG_RUN_COUNT);
      send_text(";");
      send_byte(stt_pkg::CHAR_ZERO);
   endtask

   task automatic send_fragment();
      case ($urandom_range(0, 11))
         0, 1: send_text(pick_word());
         2: begin
            send_byte(word_char(1'b1));
            repeat ($urandom_range(0, 7)) send_byte(word_char(1'b0));
         end
         3: repeat ($urandom_range(1, 6))
               send_byte(8'(stt_pkg::CHAR_DIGIT_LO + $urandom_range(0, 9)));
         4: send_byte(PUNCTUATION[$urandom_range(0, PUNCTUATION.len() - 1)]);
         5, 6: send_byte(blank_byte($urandom_range(0, 5)));
         7: begin
            send_text("//");
            repeat ($urandom_range(0, 8)) send_byte(8'($urandom_range(1, 255)));
            if ($urandom_range(0, 3) != 0) begin
               send_byte(stt_pkg::CHAR_NEWLINE);
            end else begin
               send_byte(stt_pkg::CHAR_ZERO);
            end
         end
         8: send_byte(stt_pkg::CHAR_SLASH);
         9: repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
         10: send_byte(8'($urandom_range(CHAR_HIGH_LO, CHAR_MAX)));
         default: begin
            if ($urandom_range(0, 3) == 0) begin
               send_byte(stt_pkg::CHAR_ZERO);
            end else begin
               send_byte(blank_byte($urandom_range(0, 5)));
            end
         end
      endcase
   endtask

   task automatic test_random_text();
      int stop_at;
      stop_at = bytes_sent + RANDOM_BYTES;
      while (bytes_sent < stop_at) begin
         if ($urandom_range(0, 49) == 0) begin
            send_idle_pct = pick_pct();
            stall_pct     = pick_pct();
         end
         send_fragment();
      end
      send_byte(stt_pkg::CHAR_ZERO);
   endtask

   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.source_byte = stt_pkg::CHAR_ZERO;
      clear_scanner();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 15;
      stall_pct     = 15;
      test_single_chars();
      test_runs();
      test_keyword();
      test_slash_and_comment();
      test_whitespace();
      test_long_runs();
      send_idle_pct = 15;
      stall_pct     = 50;
      test_random_text();

      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("source_text_tokenizer test passed");
      end else begin
         $display("source_text_tokenizer test failed");
      end
      $finish;
   end

endmodule
